>>> design/hpb_pkg.sv
// ----------------------------------------------------------------------------
// HPACK header block parser package
// Shared types, event codes and sizing constants for the header block parser.
// ----------------------------------------------------------------------------
package hpb_pkg;

  // Default sizing of the parser.
  localparam int STATIC_ENTRIES_DEF      = 61;
  localparam int MAX_DYNAMIC_ENTRIES_DEF = 4096;
  localparam int VALUE_BITS_DEF          = 32;

  // Depth of the record queue between parser and event serialiser.
  localparam int QUEUE_DEPTH = 4;
  localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

  // Representation prefix bits and prefix masks.
  localparam logic [7:0] BIT_INDEXED  = 8'h80;
  localparam logic [7:0] BIT_INCR     = 8'h40;
  localparam logic [7:0] BIT_SIZE     = 8'h20;
  localparam logic [7:0] BIT_NEVER    = 8'h10;
  localparam logic [7:0] MASK_7       = 8'h7F;
  localparam logic [7:0] MASK_6       = 8'h3F;
  localparam logic [7:0] MASK_5       = 8'h1F;
  localparam logic [7:0] MASK_4       = 8'h0F;
  // A continuation byte is refused once the shift has passed this value.
  localparam logic [5:0] SHIFT_LIMIT  = 6'(64 - 7);
  localparam logic [5:0] SHIFT_STEP   = 6'd7;

  // Event kinds.
  localparam logic [3:0] EV_INDEXED     = 4'd0;
  localparam logic [3:0] EV_LIT_START   = 4'd1;
  localparam logic [3:0] EV_NAME_BYTE   = 4'd2;
  localparam logic [3:0] EV_VALUE_BYTE  = 4'd3;
  localparam logic [3:0] EV_EMPTY_NAME  = 4'd4;
  localparam logic [3:0] EV_EMPTY_VALUE = 4'd5;
  localparam logic [3:0] EV_SIZE_UPDATE = 4'd6;
  localparam logic [3:0] EV_BLOCK_OK    = 4'd7;
  localparam logic [3:0] EV_ERROR       = 4'd8;

  // Literal modes.
  localparam logic [1:0] MODE_INCR    = 2'd0;
  localparam logic [1:0] MODE_WITHOUT = 2'd1;
  localparam logic [1:0] MODE_NEVER   = 2'd2;

  // Error codes.
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_ZERO_IDX  = 3'd1;
  localparam logic [2:0] ERR_IDX_RANGE = 3'd2;
  localparam logic [2:0] ERR_INT_OVF   = 3'd3;
  localparam logic [2:0] ERR_TRUNCATED = 3'd4;

  // One octet of the header block.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       block_last;
  } in_item_t;

  // One event as delivered on the result channel.
  typedef struct packed {
    logic [3:0]  event_kind;
    logic [31:0] event_value;
    logic [1:0]  literal_mode;
    logic        huffman_flag;
    logic        string_end;
    logic [2:0]  error_code;
    logic        run_last;
  } out_item_t;

  // One event inside the block, before its position in the run is known.
  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] value;
    logic [1:0]  mode;
    logic        huff;
    logic        send;
    logic [2:0]  err;
  } evt_t;

  // All events caused by one octet: e0 always, e1 when two is set.
  typedef struct packed {
    evt_t e0;
    evt_t e1;
    logic two;
  } rec_t;

endpackage

>>> design/hpb_front.sv
// ----------------------------------------------------------------------------
// HPACK parser front end
// Classifies each octet, decodes prefix integers, checks indices and builds
// one record of events per octet for the record queue.
// ----------------------------------------------------------------------------
module hpb_front #(
  parameter int STATIC_ENTRIES      = hpb_pkg::STATIC_ENTRIES_DEF,
  parameter int MAX_DYNAMIC_ENTRIES = hpb_pkg::MAX_DYNAMIC_ENTRIES_DEF,
  parameter int VALUE_BITS          = hpb_pkg::VALUE_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  hpb_pkg::in_item_t in_item,
  input  logic             q_full,
  output logic             push,
  output hpb_pkg::rec_t    push_rec
);
  import hpb_pkg::*;

  localparam int DYN_W = $clog2(MAX_DYNAMIC_ENTRIES + 1);
  localparam int LIM_W = $clog2(STATIC_ENTRIES + MAX_DYNAMIC_ENTRIES + 1);
  localparam int CMP_W = (LIM_W > VALUE_BITS) ? LIM_W : VALUE_BITS;
  localparam int SUM_W = VALUE_BITS + 7;

  typedef enum logic [6:0] {
    PH_START        = 7'b0000001,
    PH_INT_INDEXED  = 7'b0000010,
    PH_INT_NAMEIDX  = 7'b0000100,
    PH_INT_SIZE     = 7'b0001000,
    PH_INT_STRLEN   = 7'b0010000,
    PH_STR_DATA     = 7'b0100000,
    PH_STRLEN_FIRST = 7'b1000000
  } phase_t;

  phase_t                phase_r, phase_nxt;
  logic [VALUE_BITS-1:0] accum_r, accum_nxt;
  logic [5:0]            shift_r, shift_nxt;
  logic [1:0]            mode_r, mode_nxt;
  logic [VALUE_BITS-1:0] rem_r, rem_nxt;
  logic                  in_val_r, in_val_nxt;
  logic                  huff_r, huff_nxt;
  logic [DYN_W-1:0]      dyn_r, dyn_nxt;
  logic [LIM_W-1:0]      lim_r, lim_nxt;
  logic                  skip_r, skip_nxt;

  logic                  accept;
  logic [7:0]            b;
  logic [7:0]            pfx_mask;
  logic [7:0]            pfx;
  phase_t                start_phase;
  logic [SUM_W-1:0]      addend;
  logic [SUM_W-1:0]      sum;
  logic                  cont_err;
  logic                  done;
  phase_t                done_phase;
  logic [VALUE_BITS-1:0] done_v;
  logic                  in_range;
  logic                  err_now;
  logic                  str_done;
  logic                  str_end;
  evt_t                  ev0, ev1, blk_ev;
  logic                  ev0_vld, ev1_vld;

  assign accept = in_valid && !q_full;
  assign b      = in_item.data_byte;

  // Continuation octet: add seven more bits at the current shift.
  assign addend   = SUM_W'(b[6:0]) << shift_r;
  assign sum      = SUM_W'(accum_r) + addend;
  assign cont_err = (shift_r > SHIFT_LIMIT) ||
                    ((b[6:0] != 7'd0) &&
                     ((shift_r >= 6'(VALUE_BITS)) || (|sum[SUM_W-1:VALUE_BITS])));

  // Range check against the static table plus the counted dynamic entries.
  assign in_range = CMP_W'(done_v) <= CMP_W'(lim_r);

  // Parse step for one octet.
  always_comb begin
    phase_nxt   = phase_r;
    accum_nxt   = accum_r;
    shift_nxt   = shift_r;
    mode_nxt    = mode_r;
    rem_nxt     = rem_r;
    in_val_nxt  = in_val_r;
    huff_nxt    = huff_r;
    dyn_nxt     = dyn_r;
    lim_nxt     = lim_r;
    skip_nxt    = skip_r;
    ev0         = '0;
    ev0_vld     = 1'b0;
    ev1         = '0;
    ev1_vld     = 1'b0;
    blk_ev      = '0;
    err_now     = 1'b0;
    done        = 1'b0;
    done_phase  = PH_INT_STRLEN;
    done_v      = '0;
    str_done    = 1'b0;
    str_end     = 1'b0;
    pfx_mask    = MASK_7;
    start_phase = PH_INT_INDEXED;
    pfx         = '0;

    if (!skip_r) begin
      unique case (phase_r)
        PH_INT_INDEXED, PH_INT_NAMEIDX, PH_INT_SIZE, PH_INT_STRLEN: begin
          if (cont_err) begin
            err_now = 1'b1;
            ev0     = '{kind: EV_ERROR, err: ERR_INT_OVF, default: '0};
            ev0_vld = 1'b1;
          end else begin
            accum_nxt = sum[VALUE_BITS-1:0];
            shift_nxt = shift_r + SHIFT_STEP;
            if (!b[7]) begin
              done       = 1'b1;
              done_phase = phase_r;
              done_v     = sum[VALUE_BITS-1:0];
            end
          end
        end
        PH_STR_DATA: begin
          str_end = (rem_r == VALUE_BITS'(1));
          rem_nxt = rem_r - VALUE_BITS'(1);
          ev0     = '{kind: in_val_r ? EV_VALUE_BYTE : EV_NAME_BYTE, value: 32'(b),
                      mode: mode_r, huff: huff_r, send: str_end, err: ERR_NONE};
          ev0_vld  = 1'b1;
          str_done = str_end;
        end
        PH_STRLEN_FIRST: begin
          huff_nxt    = b[7];
          pfx_mask    = MASK_7;
          start_phase = PH_INT_STRLEN;
        end
        default: begin
          // Representation start: classify by the leading bits.
          if ((b & BIT_INDEXED) != 8'd0) begin
            pfx_mask    = MASK_7;
            start_phase = PH_INT_INDEXED;
          end else if ((b & BIT_INCR) != 8'd0) begin
            mode_nxt    = MODE_INCR;
            pfx_mask    = MASK_6;
            start_phase = PH_INT_NAMEIDX;
          end else if ((b & BIT_SIZE) != 8'd0) begin
            pfx_mask    = MASK_5;
            start_phase = PH_INT_SIZE;
          end else begin
            mode_nxt    = ((b & BIT_NEVER) != 8'd0) ? MODE_NEVER : MODE_WITHOUT;
            pfx_mask    = MASK_4;
            start_phase = PH_INT_NAMEIDX;
          end
        end
      endcase

      // First octet of a prefix integer, either finished or continued.
      if (phase_r == PH_STRLEN_FIRST || !(phase_r inside {PH_INT_INDEXED, PH_INT_NAMEIDX,
          PH_INT_SIZE, PH_INT_STRLEN, PH_STR_DATA})) begin
        pfx = b & pfx_mask;
        if (pfx < pfx_mask) begin
          done       = 1'b1;
          done_phase = start_phase;
          done_v     = VALUE_BITS'(pfx);
        end else begin
          accum_nxt = VALUE_BITS'(pfx_mask);
          shift_nxt = '0;
          phase_nxt = start_phase;
        end
      end

      // A finished integer is acted on according to what it encodes.
      if (done) begin
        accum_nxt = '0;
        shift_nxt = '0;
        unique case (done_phase)
          PH_INT_INDEXED: begin
            if (done_v == '0) begin
              err_now = 1'b1;
              ev0     = '{kind: EV_ERROR, err: ERR_ZERO_IDX, default: '0};
            end else if (!in_range) begin
              err_now = 1'b1;
              ev0     = '{kind: EV_ERROR, err: ERR_IDX_RANGE, default: '0};
            end else begin
              ev0       = '{kind: EV_INDEXED, value: 32'(done_v), default: '0};
              phase_nxt = PH_START;
            end
            ev0_vld = 1'b1;
          end
          PH_INT_NAMEIDX: begin
            if (done_v != '0 && !in_range) begin
              err_now = 1'b1;
              ev0     = '{kind: EV_ERROR, err: ERR_IDX_RANGE, default: '0};
            end else begin
              ev0        = '{kind: EV_LIT_START, value: 32'(done_v), mode: mode_nxt,
                             default: '0};
              in_val_nxt = (done_v != '0);
              phase_nxt  = PH_STRLEN_FIRST;
            end
            ev0_vld = 1'b1;
          end
          PH_INT_SIZE: begin
            ev0       = '{kind: EV_SIZE_UPDATE, value: 32'(done_v), default: '0};
            ev0_vld   = 1'b1;
            phase_nxt = PH_START;
          end
          default: begin
            if (done_v == '0) begin
              ev0      = '{kind: in_val_r ? EV_EMPTY_VALUE : EV_EMPTY_NAME, value: '0,
                           mode: mode_nxt, huff: huff_nxt, send: 1'b1, err: ERR_NONE};
              ev0_vld  = 1'b1;
              str_done = 1'b1;
            end else begin
              rem_nxt   = done_v;
              phase_nxt = PH_STR_DATA;
            end
          end
        endcase
      end

      // End of a name or value string.
      if (str_done) begin
        if (in_val_r) begin
          if (mode_nxt == MODE_INCR && dyn_r < DYN_W'(MAX_DYNAMIC_ENTRIES)) begin
            dyn_nxt = dyn_r + DYN_W'(1);
            lim_nxt = lim_r + LIM_W'(1);
          end
          in_val_nxt = 1'b0;
          phase_nxt  = PH_START;
        end else begin
          in_val_nxt = 1'b1;
          phase_nxt  = PH_STRLEN_FIRST;
        end
      end
    end

    // Block end report, after any event of the octet itself.
    if (in_item.block_last && !skip_r && !err_now) begin
      if (phase_nxt != PH_START) begin
        blk_ev = '{kind: EV_ERROR, err: ERR_TRUNCATED, default: '0};
      end else begin
        blk_ev = '{kind: EV_BLOCK_OK, default: '0};
      end
      if (ev0_vld) begin
        ev1     = blk_ev;
        ev1_vld = 1'b1;
      end else begin
        ev0     = blk_ev;
        ev0_vld = 1'b1;
      end
    end

    // An error or the block's last octet returns the per-block state to rest.
    if (err_now || in_item.block_last) begin
      phase_nxt  = PH_START;
      accum_nxt  = '0;
      shift_nxt  = '0;
      mode_nxt   = MODE_INCR;
      rem_nxt    = '0;
      in_val_nxt = 1'b0;
      huff_nxt   = 1'b0;
      skip_nxt   = !in_item.block_last;
    end
  end

  assign push     = accept && ev0_vld;
  assign push_rec = '{e0: ev0, e1: ev1, two: ev1_vld};

  // Parser state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_START;
      accum_r  <= '0;
      shift_r  <= '0;
      mode_r   <= MODE_INCR;
      rem_r    <= '0;
      in_val_r <= 1'b0;
      huff_r   <= 1'b0;
      dyn_r    <= '0;
      lim_r    <= LIM_W'(STATIC_ENTRIES);
      skip_r   <= 1'b0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      accum_r  <= accum_nxt;
      shift_r  <= shift_nxt;
      mode_r   <= mode_nxt;
      rem_r    <= rem_nxt;
      in_val_r <= in_val_nxt;
      huff_r   <= huff_nxt;
      dyn_r    <= dyn_nxt;
      lim_r    <= lim_nxt;
      skip_r   <= skip_nxt;
    end
  end

endmodule

>>> design/hpb_queue.sv
// ----------------------------------------------------------------------------
// HPACK parser record queue
// Short first-in first-out queue of per-octet event records between the
// parser and the event serialiser.
// ----------------------------------------------------------------------------
module hpb_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  hpb_pkg::rec_t push_rec,
  input  logic          pop,
  output logic          full,
  output logic          head_valid,
  output hpb_pkg::rec_t head_rec
);
  import hpb_pkg::*;

  rec_t               slot_r [QUEUE_DEPTH];
  logic [Q_PTR_W-1:0] wr_r, wr_nxt;
  logic [Q_PTR_W-1:0] rd_r, rd_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               do_pop;

  assign full       = (cnt_r == Q_CNT_W'(QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_rec   = slot_r[rd_r];
  assign do_pop     = pop && head_valid;

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_r + Q_PTR_W'(1);
    end
    if (do_pop) begin
      rd_nxt = (rd_r == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_r + Q_PTR_W'(1);
    end
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + Q_CNT_W'(1);
    end else if (do_pop && !push) begin
      cnt_nxt = cnt_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Record storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= push_rec;
    end
  end

endmodule

>>> design/hpb_back.sv
// ----------------------------------------------------------------------------
// HPACK parser event serialiser
// Takes records from the queue and delivers their events one per request
// through an output register, marking the last event of each octet.
// ----------------------------------------------------------------------------
module hpb_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_valid,
  input  hpb_pkg::rec_t      head_rec,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output hpb_pkg::out_item_t out_item
);
  import hpb_pkg::*;

  logic      out_valid_r;
  out_item_t out_item_r;
  logic      sel_r;
  logic      load;
  logic      last_of;
  evt_t      pick;

  // The output register takes a new event whenever it is empty or draining.
  assign load    = head_valid && (!out_valid_r || !out_stall);
  assign pick    = sel_r ? head_rec.e1 : head_rec.e0;
  assign last_of = !head_rec.two || sel_r;
  assign pop     = load && last_of;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sel_r       <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
      sel_r       <= !last_of;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (load) begin
      out_item_r.event_kind   <= pick.kind;
      out_item_r.event_value  <= pick.value;
      out_item_r.literal_mode <= pick.mode;
      out_item_r.huffman_flag <= pick.huff;
      out_item_r.string_end   <= pick.send;
      out_item_r.error_code   <= pick.err;
      out_item_r.run_last     <= last_of;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

>>> design/hpack_header_block_parser.sv
// ----------------------------------------------------------------------------
// HPACK header block parser
// Representation-layer parser for HPACK header blocks: one octet in, a short
// run of events out.
// ----------------------------------------------------------------------------
// The parser takes one header-block octet per clock cycle while in_stall is
// low and reports indexed fields, literal starts, string bytes, table size
// updates, block completion and errors as events; each octet causes zero,
// one or two events, and the last event of an octet carries run_last. The
// front end parses a whole octet in the cycle it is accepted, and the output
// register delivers one event per cycle while out_stall is low. A four-record
// queue lets the parser keep accepting octets while the output side is
// stalled; in_stall rises only when that queue is full. The first result of
// an octet passes through the queue and then the output register before it
// is offered. No clearing pass follows reset.
module hpack_header_block_parser #(
  parameter int STATIC_ENTRIES      = hpb_pkg::STATIC_ENTRIES_DEF,
  parameter int MAX_DYNAMIC_ENTRIES = hpb_pkg::MAX_DYNAMIC_ENTRIES_DEF,
  parameter int VALUE_BITS          = hpb_pkg::VALUE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  hpb_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output hpb_pkg::out_item_t out_item
);
  import hpb_pkg::*;

  logic q_full;
  logic push;
  rec_t push_rec;
  logic pop;
  logic head_valid;
  rec_t head_rec;

  assign in_stall = q_full;

  // Parser front end.
  hpb_front #(
    .STATIC_ENTRIES      (STATIC_ENTRIES),
    .MAX_DYNAMIC_ENTRIES (MAX_DYNAMIC_ENTRIES),
    .VALUE_BITS          (VALUE_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_item  (in_item),
    .q_full   (q_full),
    .push     (push),
    .push_rec (push_rec)
  );

  // Record queue.
  hpb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_rec   (push_rec),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_rec   (head_rec)
  );

  // Event serialiser.
  hpb_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_rec   (head_rec),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

endmodule
